// ----- hdl/raf_pkg.sv -----
// ----------------------------------------------------------------------------
// raf_pkg: shared types and constants of the region annulus finder
// Item layouts, operation codes, controller states, command/status bundles
// and the neighbor scan order.
// ----------------------------------------------------------------------------
package raf_pkg;

	// Fixed field widths of the item channels
	localparam int ETA_W    = 5;
	localparam int PHI_W    = 5;
	localparam int ENERGY_W = 10;
	localparam int COUNT_W  = 4;
	localparam int STEP_W   = 3;

	// Number of neighbor reads per query, and the last scan step
	localparam int NBR_COUNT = 8;
	localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(NBR_COUNT - 1);

	// Offset codes: 0 is -1, 1 is 0, 2 is +1
	localparam logic [1:0] OFS_MINUS = 2'd0;
	localparam logic [1:0] OFS_ZERO  = 2'd1;
	localparam logic [1:0] OFS_PLUS  = 2'd2;

	// Operation codes
	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	typedef struct packed {
		logic                operation;
		logic [ETA_W-1:0]    cell_eta;
		logic [PHI_W-1:0]    cell_phi;
		logic [ENERGY_W-1:0] region_energy;
		logic                mip_bit;
		logic                tau_veto_bit;
	} raf_in_item_t;

	typedef struct packed {
		logic [ENERGY_W-1:0] highest_neighbor_energy;
		logic [ENERGY_W-1:0] second_neighbor_energy;
		logic [COUNT_W-1:0]  mips_in_annulus;
		logic [COUNT_W-1:0]  eg_flags_in_annulus;
		logic                highest_has_mip;
	} raf_out_item_t;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SCAN,
		ST_FINISH
	} raf_state_t;

	// Controller to datapath
	typedef struct packed {
		logic              clear_wr;
		logic              item_wr;
		logic              cell_load;
		logic              acc_clear;
		logic              scan_rd;
		logic [STEP_W-1:0] step;
		logic              result_load;
	} raf_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic clear_last;
	} raf_stat_t;

	// Scan order: phi offset major, eta offset minor, center skipped.
	// Returns {phi offset code, eta offset code}.
	function automatic logic [3:0] raf_step_ofs(input logic [STEP_W-1:0] step);
		logic [3:0] ofs;
		case (step)
			3'd0:    ofs = {OFS_MINUS, OFS_MINUS};
			3'd1:    ofs = {OFS_MINUS, OFS_ZERO};
			3'd2:    ofs = {OFS_MINUS, OFS_PLUS};
			3'd3:    ofs = {OFS_ZERO,  OFS_MINUS};
			3'd4:    ofs = {OFS_ZERO,  OFS_PLUS};
			3'd5:    ofs = {OFS_PLUS,  OFS_MINUS};
			3'd6:    ofs = {OFS_PLUS,  OFS_ZERO};
			3'd7:    ofs = {OFS_PLUS,  OFS_PLUS};
			default: ofs = {OFS_ZERO,  OFS_ZERO};
		endcase
		return ofs;
	endfunction

endpackage

// ----- hdl/raf_stream_if.sv -----
// ----------------------------------------------------------------------------
// raf_stream_if: valid/ready item channel
// Carries one item of the given payload type per accepted handshake.
// ----------------------------------------------------------------------------
interface raf_stream_if #(
	parameter type item_t = logic
);
	logic  valid;
	logic  ready;
	item_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// ----- hdl/raf_datapath.sv -----
// ----------------------------------------------------------------------------
// raf_datapath: region memory, neighbor addressing and annulus accumulation
// Holds the region grid, generates neighbor addresses per scan step,
// accumulates maxima and flag counts, and keeps the result register.
// ----------------------------------------------------------------------------
module raf_datapath #(
	parameter int ETA_COUNT   = 22,
	parameter int PHI_COUNT   = 18,
	parameter int ENERGY_BITS = 10
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  raf_pkg::raf_in_item_t  in_item,
	input  raf_pkg::raf_cmd_t      cmd,
	output raf_pkg::raf_stat_t     stat,
	output raf_pkg::raf_out_item_t out_item
);

	localparam int DEPTH = ETA_COUNT * PHI_COUNT;
	localparam int AW    = $clog2(DEPTH);
	localparam int PW    = $clog2(PHI_COUNT);
	localparam int TW    = $clog2(ETA_COUNT);
	localparam int EW    = (ENERGY_BITS < raf_pkg::ENERGY_W) ? ENERGY_BITS : raf_pkg::ENERGY_W;
	localparam int MW    = EW + 3;
	// Entry layout: {valid, mip, tau veto, energy}
	localparam int B_VALID = EW + 2;
	localparam int B_MIP   = EW + 1;
	localparam int B_TAU   = EW;
	localparam int PHI_VALS = 1 << raf_pkg::PHI_W;

	// Phi reduction table over all input codes
	logic [PW-1:0] phi_mod_tab [PHI_VALS];
	for (genvar g = 0; g < PHI_VALS; g++) begin : g_phi_mod
		assign phi_mod_tab[g] = PW'(g % PHI_COUNT);
	end

	logic [PW-1:0]  in_phi;
	logic [6:0]     in_eta_ext;
	logic           in_eta_ok;
	logic [AW-1:0]  in_addr;
	logic [MW-1:0]  mem [DEPTH];
	logic [AW-1:0]  clr_addr_q;
	logic           mem_we;
	logic [AW-1:0]  wr_addr;
	logic [MW-1:0]  wr_data;
	logic [raf_pkg::ETA_W-1:0] eta_q;
	logic [PW-1:0]  phi_q;
	logic [1:0]     dp_code;
	logic [1:0]     de_code;
	logic [PW-1:0]  nb_phi;
	logic [6:0]     nb_eta;
	logic           nb_ok;
	logic [AW-1:0]  rd_addr;
	logic [MW-1:0]  rd_s1;
	logic           acc_en_s1;
	logic [EW-1:0]  top_q, second_q, top_n, second_n;
	logic [raf_pkg::COUNT_W-1:0] mips_q, egs_q, mips_n, egs_n;
	logic           top_mip_q, top_eg_q, top_mip_n, top_eg_n;
	logic           rd_valid, rd_mip, rd_eg;
	logic [EW-1:0]  rd_energy;
	raf_pkg::raf_out_item_t out_q;

	// Input coordinates
	assign in_phi     = phi_mod_tab[in_item.cell_phi];
	assign in_eta_ext = 7'(in_item.cell_eta);
	assign in_eta_ok  = in_eta_ext < 7'(ETA_COUNT);
	assign in_addr    = AW'(AW'(in_eta_ext[TW-1:0]) * AW'(PHI_COUNT)) + AW'(in_phi);

	// Clearing pass address
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q <= '0;
		end else if (cmd.clear_wr) begin
			clr_addr_q <= clr_addr_q + 1'b1;
		end
	end
	assign stat.clear_last = clr_addr_q == AW'(DEPTH - 1);

	// Write port select
	assign mem_we  = cmd.clear_wr || (cmd.item_wr && in_eta_ok);
	assign wr_addr = cmd.clear_wr ? clr_addr_q : in_addr;
	assign wr_data = cmd.clear_wr ? '0 :
		{1'b1, in_item.mip_bit, in_item.tau_veto_bit, in_item.region_energy[EW-1:0]};

	// Query cell latch
	always_ff @(posedge clk) begin
		if (cmd.cell_load) begin
			eta_q <= in_item.cell_eta;
			phi_q <= in_phi;
		end
	end

	// Neighbor address for the current scan step
	assign {dp_code, de_code} = raf_pkg::raf_step_ofs(cmd.step);
	always_comb begin
		case (dp_code)
			raf_pkg::OFS_MINUS: nb_phi = (phi_q == '0) ? PW'(PHI_COUNT - 1) : phi_q - 1'b1;
			raf_pkg::OFS_PLUS:  nb_phi = (phi_q == PW'(PHI_COUNT - 1)) ? '0 : phi_q + 1'b1;
			default:            nb_phi = phi_q;
		endcase
	end
	assign nb_eta  = 7'(eta_q) + 7'(de_code) - 7'd1;
	assign nb_ok   = nb_eta < 7'(ETA_COUNT);
	assign rd_addr = AW'(AW'(nb_eta[TW-1:0]) * AW'(PHI_COUNT)) + AW'(nb_phi);

	// Region memory, registered read
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[wr_addr] <= wr_data;
		end
		if (cmd.scan_rd) begin
			rd_s1 <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_en_s1 <= 1'b0;
		end else begin
			acc_en_s1 <= cmd.scan_rd && nb_ok;
		end
	end

	// Accumulation of one neighbor
	assign rd_valid  = acc_en_s1 && rd_s1[B_VALID];
	assign rd_mip    = rd_s1[B_MIP];
	assign rd_eg     = !rd_s1[B_MIP] && !rd_s1[B_TAU];
	assign rd_energy = rd_s1[EW-1:0];

	always_comb begin
		top_n     = top_q;
		second_n  = second_q;
		top_mip_n = top_mip_q;
		top_eg_n  = top_eg_q;
		mips_n    = mips_q;
		egs_n     = egs_q;
		if (rd_valid) begin
			if (rd_energy > top_q) begin
				second_n  = top_q;
				top_n     = rd_energy;
				top_mip_n = rd_mip;
				top_eg_n  = rd_eg;
			end else if (rd_energy > second_q) begin
				second_n = rd_energy;
			end
			mips_n = mips_q + raf_pkg::COUNT_W'(rd_mip);
			egs_n  = egs_q + raf_pkg::COUNT_W'(rd_eg);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			top_q     <= '0;
			second_q  <= '0;
			top_mip_q <= 1'b0;
			top_eg_q  <= 1'b0;
			mips_q    <= '0;
			egs_q     <= '0;
		end else if (cmd.acc_clear) begin
			top_q     <= '0;
			second_q  <= '0;
			top_mip_q <= 1'b0;
			top_eg_q  <= 1'b0;
			mips_q    <= '0;
			egs_q     <= '0;
		end else begin
			top_q     <= top_n;
			second_q  <= second_n;
			top_mip_q <= top_mip_n;
			top_eg_q  <= top_eg_n;
			mips_q    <= mips_n;
			egs_q     <= egs_n;
		end
	end

	// Result register: highest neighbor taken out of the counts
	always_ff @(posedge clk) begin
		if (cmd.result_load) begin
			out_q.highest_neighbor_energy <= raf_pkg::ENERGY_W'(top_n);
			out_q.second_neighbor_energy  <= raf_pkg::ENERGY_W'(second_n);
			out_q.mips_in_annulus         <= mips_n - raf_pkg::COUNT_W'(top_mip_n);
			out_q.eg_flags_in_annulus     <= egs_n - raf_pkg::COUNT_W'(top_eg_n);
			out_q.highest_has_mip         <= top_mip_n;
		end
	end
	assign out_item = out_q;

	// Checks
	a_second_le_top: assert property (@(posedge clk) disable iff (!arst_n)
		second_q <= top_q)
		else $error("second maximum above maximum");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(mips_q <= raf_pkg::COUNT_W'(raf_pkg::NBR_COUNT)) &&
		(egs_q <= raf_pkg::COUNT_W'(raf_pkg::NBR_COUNT)))
		else $error("annulus count above neighbor count");
	a_top_mip_counted: assert property (@(posedge clk) disable iff (!arst_n)
		top_mip_q |-> (mips_q != '0))
		else $error("highest neighbor mip not counted");

endmodule

// ----- hdl/raf_ctrl.sv -----
// ----------------------------------------------------------------------------
// raf_ctrl: sequencing of the region annulus finder
// Runs the clearing pass, accepts items, steps the eight-neighbor scan
// and hands the result to the output register.
// ----------------------------------------------------------------------------
module raf_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_op,
	output logic               in_ready,
	output logic               out_valid,
	input  logic               out_ready,
	output raf_pkg::raf_cmd_t  cmd,
	input  raf_pkg::raf_stat_t stat
);

	raf_pkg::raf_state_t state_q, state_n;
	logic [raf_pkg::STEP_W-1:0] step_q;
	logic out_valid_q;
	logic out_free;
	logic accept;

	assign out_free = !out_valid_q || out_ready;
	assign accept   = in_valid && in_ready;

	// Next state
	always_comb begin
		state_n = state_q;
		case (state_q)
			raf_pkg::ST_CLEAR: begin
				if (stat.clear_last) state_n = raf_pkg::ST_IDLE;
			end
			raf_pkg::ST_IDLE: begin
				if (accept && in_op == raf_pkg::OP_QUERY) state_n = raf_pkg::ST_SCAN;
			end
			raf_pkg::ST_SCAN: begin
				if (step_q == raf_pkg::STEP_LAST) state_n = raf_pkg::ST_FINISH;
			end
			raf_pkg::ST_FINISH: begin
				if (out_free) begin
					state_n = (accept && in_op == raf_pkg::OP_QUERY) ?
						raf_pkg::ST_SCAN : raf_pkg::ST_IDLE;
				end
			end
			default: state_n = raf_pkg::ST_CLEAR;
		endcase
	end

	// Outputs
	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			raf_pkg::ST_CLEAR: begin
				cmd.clear_wr = 1'b1;
			end
			raf_pkg::ST_IDLE: begin
				in_ready = 1'b1;
			end
			raf_pkg::ST_SCAN: begin
				cmd.scan_rd = 1'b1;
				cmd.step    = step_q;
			end
			raf_pkg::ST_FINISH: begin
				cmd.result_load = out_free;
				in_ready        = out_free;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
		// item taken in idle or while finishing
		if (in_ready && in_valid) begin
			if (in_op == raf_pkg::OP_QUERY) begin
				cmd.cell_load = 1'b1;
				cmd.acc_clear = 1'b1;
			end else begin
				cmd.item_wr = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= raf_pkg::ST_CLEAR;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (cmd.scan_rd) begin
				step_q <= step_q + 1'b1;
			end
			if (cmd.result_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end
	assign out_valid = out_valid_q;

	// Checks
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.result_load |-> (!out_valid_q || out_ready))
		else $error("result overwritten before taken");
	a_scan_to_finish: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == raf_pkg::ST_SCAN && step_q == raf_pkg::STEP_LAST)
		|=> (state_q == raf_pkg::ST_FINISH))
		else $error("scan did not end after last neighbor");
	a_step_idle_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == raf_pkg::ST_IDLE || state_q == raf_pkg::ST_FINISH) |-> (step_q == '0))
		else $error("scan step counter not rewound");
	a_clear_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == raf_pkg::ST_CLEAR) |-> (!in_ready && !cmd.scan_rd))
		else $error("activity during clearing pass");

endmodule

// ----- hdl/region_annulus_finder_core.sv -----
// Sequence: a write item is stored at its accept edge; a query reads its 8
// neighbors in the scan state (one entry per cycle, single memory read port),
// then the finishing state loads the result register once the output is free.
// Throughput: one write item per cycle while no query is busy. Reset: arst_n
// clears control; a clearing pass, with ready held low, then invalidates all
// ETA_COUNT*PHI_COUNT (396 by default) region entries.
// ----------------------------------------------------------------------------
// region_annulus_finder_core: region grid with annulus query
// Stores region energy and flags; a query reports the highest and second
// highest neighbor energy and the mip and eg counts of the other neighbors.
// ----------------------------------------------------------------------------
module region_annulus_finder_core #(
	parameter int ETA_COUNT   = 22,
	parameter int PHI_COUNT   = 18,
	parameter int ENERGY_BITS = 10
) (
	input logic          clk,
	input logic          arst_n,
	raf_stream_if.sink   req,
	raf_stream_if.source rsp
);

	raf_pkg::raf_cmd_t      cmd;
	raf_pkg::raf_stat_t     stat;
	raf_pkg::raf_in_item_t  in_item;
	raf_pkg::raf_out_item_t out_item;

	assign in_item  = req.data;
	assign rsp.data = out_item;

	raf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_op     (in_item.operation),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.cmd       (cmd),
		.stat      (stat)
	);

	raf_datapath #(
		.ETA_COUNT   (ETA_COUNT),
		.PHI_COUNT   (PHI_COUNT),
		.ENERGY_BITS (ENERGY_BITS)
	) u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_item  (in_item),
		.cmd      (cmd),
		.stat     (stat),
		.out_item (out_item)
	);

endmodule

// ----- tb/region_annulus_finder_core_tb.sv -----
// ----------------------------------------------------------------------------
// region_annulus_finder_core_tb: self-checking regression of the annulus finder
// Writes region entries and queries annuli through the item channels, predicts
// each query result from a private copy of the region grid, and compares every
// result field by field, with random idling on both channels.
// ----------------------------------------------------------------------------
module region_annulus_finder_core_tb;

	localparam int ETA_COUNT   = 22;
	localparam int PHI_COUNT   = 18;
	localparam int ENERGY_BITS = 10;
	localparam int CELL_TOTAL  = ETA_COUNT * PHI_COUNT;
	localparam int STALL_LIMIT = 3000;
	localparam int DRAIN_CYCLES = 20;
	localparam int PRINT_LIMIT = 100;
	localparam logic [raf_pkg::ENERGY_W-1:0] ENERGY_MASK =
		raf_pkg::ENERGY_W'((1 << ENERGY_BITS) - 1);

	logic clk;
	logic arst_n;

	raf_stream_if #(.item_t(raf_pkg::raf_in_item_t))  req_if ();
	raf_stream_if #(.item_t(raf_pkg::raf_out_item_t)) rsp_if ();

	region_annulus_finder_core #(
		.ETA_COUNT  (ETA_COUNT),
		.PHI_COUNT  (PHI_COUNT),
		.ENERGY_BITS(ENERGY_BITS)
	) uut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_if),
		.rsp   (rsp_if)
	);

	// Private copy of the region grid
	logic                         grid_valid  [CELL_TOTAL];
	logic [raf_pkg::ENERGY_W-1:0] grid_energy [CELL_TOTAL];
	logic                         grid_mip    [CELL_TOTAL];
	logic                         grid_veto   [CELL_TOTAL];

	raf_pkg::raf_out_item_t annulus_expected[$];
	int                     fail_count = 0;
	int                     quiet_cycles = 0;
	bit                     idle_on = 1'b1;

	// Clock
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	task automatic report_mismatch(input string msg);
		fail_count++;
		if (fail_count <= PRINT_LIMIT)
			$display("ERROR @%0t: %s", $time, msg);
	endtask

	// Annulus of a cell as the grid stands now
	function automatic raf_pkg::raf_out_item_t annulus_predict(
			input logic [raf_pkg::ETA_W-1:0] eta,
			input logic [raf_pkg::PHI_W-1:0] phi);
		raf_pkg::raf_out_item_t res;
		int phi_r, np, ne, idx;
		logic [raf_pkg::ENERGY_W-1:0] top, second;
		logic [raf_pkg::COUNT_W-1:0] mips, egs;
		logic top_mip, top_eg, eg;
		top = '0; second = '0; mips = '0; egs = '0;
		top_mip = 1'b0; top_eg = 1'b0;
		phi_r = int'(phi) % PHI_COUNT;
		for (int dp = -1; dp <= 1; dp++) begin
			np = (phi_r + PHI_COUNT + dp) % PHI_COUNT;
			for (int de = -1; de <= 1; de++) begin
				ne = int'(eta) + de;
				if (dp == 0 && de == 0) continue;
				if (ne < 0 || ne >= ETA_COUNT) continue;
				idx = ne * PHI_COUNT + np;
				if (!grid_valid[idx]) continue;
				eg = !grid_mip[idx] && !grid_veto[idx];
				if (grid_energy[idx] > top) begin
					second  = top;
					top     = grid_energy[idx];
					top_mip = grid_mip[idx];
					top_eg  = eg;
				end else if (grid_energy[idx] > second) begin
					second = grid_energy[idx];
				end
				if (grid_mip[idx]) mips++;
				if (eg) egs++;
			end
		end
		if (top_mip) mips--;
		if (top_eg) egs--;
		res.highest_neighbor_energy = top;
		res.second_neighbor_energy  = second;
		res.mips_in_annulus         = mips;
		res.eg_flags_in_annulus     = egs;
		res.highest_has_mip         = top_mip;
		return res;
	endfunction

	// Apply an accepted item: store a write, or queue the query's result
	function automatic void region_grid_apply(input raf_pkg::raf_in_item_t it);
		int idx;
		if (it.operation == raf_pkg::OP_WRITE) begin
			if (int'(it.cell_eta) < ETA_COUNT) begin
				idx = int'(it.cell_eta) * PHI_COUNT + int'(it.cell_phi) % PHI_COUNT;
				grid_valid[idx]  = 1'b1;
				grid_energy[idx] = it.region_energy & ENERGY_MASK;
				grid_mip[idx]    = it.mip_bit;
				grid_veto[idx]   = it.tau_veto_bit;
			end
		end else begin
			annulus_expected.insert(annulus_expected.size(),
				annulus_predict(it.cell_eta, it.cell_phi));
		end
	endfunction

	function automatic raf_pkg::raf_in_item_t make_write(input int eta, input int phi,
			input int energy, input bit mip, input bit veto);
		raf_pkg::raf_in_item_t it;
		it.operation     = raf_pkg::OP_WRITE;
		it.cell_eta      = raf_pkg::ETA_W'(eta);
		it.cell_phi      = raf_pkg::PHI_W'(phi);
		it.region_energy = raf_pkg::ENERGY_W'(energy);
		it.mip_bit       = mip;
		it.tau_veto_bit  = veto;
		return it;
	endfunction

	// Query; the write-only fields carry junk
	function automatic raf_pkg::raf_in_item_t make_query(input int eta, input int phi);
		raf_pkg::raf_in_item_t it;
		it.operation     = raf_pkg::OP_QUERY;
		it.cell_eta      = raf_pkg::ETA_W'(eta);
		it.cell_phi      = raf_pkg::PHI_W'(phi);
		it.region_energy = raf_pkg::ENERGY_W'($urandom);
		it.mip_bit       = 1'($urandom);
		it.tau_veto_bit  = 1'($urandom);
		return it;
	endfunction

	// Energy mix: zeros, full scale, small values for ties, anything
	function automatic int pick_energy();
		case ($urandom_range(0, 7))
			0:       return 0;
			1:       return (1 << raf_pkg::ENERGY_W) - 1;
			2, 3:    return $urandom_range(0, 3);
			default: return $urandom_range(0, (1 << raf_pkg::ENERGY_W) - 1);
		endcase
	endfunction

	// Send one item; called and returns at a falling edge
	task automatic send_item(input raf_pkg::raf_in_item_t it);
		int gap;
		gap = idle_on ? $urandom_range(0, 4) : 0;
		if (gap > 0) begin
			req_if.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_if.valid = 1'b1;
		req_if.data  = it;
		do @(posedge clk); while (!req_if.ready);
		region_grid_apply(it);
		@(negedge clk);
	endtask

	// Compare one accepted result with the oldest expectation
	task automatic annulus_check(input raf_pkg::raf_out_item_t got);
		raf_pkg::raf_out_item_t want;
		if (annulus_expected.size() == 0) begin
			report_mismatch("result with no query pending");
		end else begin
			want = annulus_expected.pop_front();
			if (got.highest_neighbor_energy !== want.highest_neighbor_energy)
				report_mismatch($sformatf("highest_neighbor_energy got %0d want %0d",
					got.highest_neighbor_energy, want.highest_neighbor_energy));
			if (got.second_neighbor_energy !== want.second_neighbor_energy)
				report_mismatch($sformatf("second_neighbor_energy got %0d want %0d",
					got.second_neighbor_energy, want.second_neighbor_energy));
			if (got.mips_in_annulus !== want.mips_in_annulus)
				report_mismatch($sformatf("mips_in_annulus got %0d want %0d",
					got.mips_in_annulus, want.mips_in_annulus));
			if (got.eg_flags_in_annulus !== want.eg_flags_in_annulus)
				report_mismatch($sformatf("eg_flags_in_annulus got %0d want %0d",
					got.eg_flags_in_annulus, want.eg_flags_in_annulus));
			if (got.highest_has_mip !== want.highest_has_mip)
				report_mismatch($sformatf("highest_has_mip got %0d want %0d",
					got.highest_has_mip, want.highest_has_mip));
		end
	endtask

	// Result sink: random stall per item, sometimes ready before valid
	initial begin
		int stall;
		bit wait_first;
		rsp_if.ready = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			stall      = idle_on ? $urandom_range(0, 4) : 0;
			wait_first = 1'($urandom);
			if (wait_first && !rsp_if.valid) begin
				rsp_if.ready = 1'b0;
				while (!rsp_if.valid) @(negedge clk);
			end
			if (stall > 0) begin
				rsp_if.ready = 1'b0;
				repeat (stall) @(negedge clk);
			end
			rsp_if.ready = 1'b1;
			do @(posedge clk); while (!rsp_if.valid);
			annulus_check(rsp_if.data);
			@(negedge clk);
		end
	end

	// Watchdog: cycles without any accepted item
	always @(posedge clk) begin
		if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("region_annulus_finder_core regression: fail");
			$finish;
		end
	end

	// Queries before anything is written: all zero
	task automatic test_unwritten_annulus();
		send_item(make_query(0, 0));
		send_item(make_query(31, 31));
	endtask

	// Grid edges, phi wrap, ties, out-of-range cells, zero energy
	task automatic test_edge_annulus();
		send_item(make_write(1, 0, 1023, 1'b1, 1'b0));
		send_item(make_write(0, 17, 500, 1'b0, 1'b0));  // neighbor across the phi wrap
		send_item(make_write(1, 17, 500, 1'b0, 1'b1));  // equal energy: second, not highest
		send_item(make_write(0, 1, 0, 1'b0, 1'b0));     // zero energy still counts as eg
		send_item(make_write(1, 19, 700, 1'b1, 1'b1));  // phi 19 lands on phi 1
		send_item(make_write(25, 0, 900, 1'b0, 1'b0));  // eta beyond the grid, dropped
		send_item(make_query(0, 0));
		send_item(make_query(0, 18));                   // same cell through phi wrap
		send_item(make_write(21, 5, 1023, 1'b0, 1'b0));
		send_item(make_write(21, 4, 1023, 1'b0, 1'b0)); // tie at full scale
		send_item(make_query(22, 5));                   // center off the grid
		send_item(make_query(20, 5));
		send_item(make_query(31, 17));
		send_item(make_write(10, 10, 0, 1'b1, 1'b1));   // only zero-energy neighbor
		send_item(make_query(10, 11));
		send_item(make_query(11, 9));
	endtask

	// Neighborhood bursts with random content, plus noise items
	task automatic test_random_traffic(input int n_items);
		int sent, ce, cp, burst, ne;
		raf_pkg::raf_in_item_t it;
		sent = 0;
		while (sent < n_items) begin
			if ($urandom_range(0, 99) < 6)
				idle_on = !idle_on;
			if ($urandom_range(0, 9) < 8) begin
				ce    = ($urandom_range(0, 3) == 0) ? (($urandom_range(0, 1) != 0) ? 0 : 21)
					: $urandom_range(0, ETA_COUNT - 1);
				cp    = $urandom_range(0, 31);
				burst = $urandom_range(1, 6);
				repeat (burst) begin
					ne = ce + $urandom_range(0, 2) - 1;
					send_item(make_write(ne, cp + $urandom_range(0, 2) + PHI_COUNT - 1,
						pick_energy(), 1'($urandom), 1'($urandom)));
					if (ne >= 0 && ne < ETA_COUNT) sent++;
				end
				send_item(make_query(ce, cp));
				sent++;
				if ($urandom_range(0, 2) == 0) begin
					send_item(make_query(ce + $urandom_range(0, 2) - 1, cp + 1));
					sent++;
				end
			end else begin
				it = ($urandom_range(0, 1) != 0) ? make_query($urandom_range(0, 31),
					$urandom_range(0, 31)) : make_write($urandom_range(0, 31),
					$urandom_range(0, 31), pick_energy(), 1'($urandom), 1'($urandom));
				send_item(it);
				if (it.operation == raf_pkg::OP_QUERY || int'(it.cell_eta) < ETA_COUNT)
					sent++;
			end
		end
	endtask

	// Main sequence
	initial begin
		for (int i = 0; i < CELL_TOTAL; i++) begin
			grid_valid[i]  = 1'b0;
			grid_energy[i] = '0;
			grid_mip[i]    = 1'b0;
			grid_veto[i]   = 1'b0;
		end
		arst_n       = 1'b0;
		req_if.valid = 1'b0;
		req_if.data  = '0;
		repeat (7) @(negedge clk);
		arst_n = 1'b1;

		test_unwritten_annulus();
		test_edge_annulus();
		idle_on = 1'b0;
		test_random_traffic(1100);
		req_if.valid = 1'b0;

		// Drain outstanding results
		while (annulus_expected.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (fail_count == 0)
			$display("region_annulus_finder_core regression: pass");
		else
			$display("region_annulus_finder_core regression: fail");
		$finish;
	end

endmodule
